[rtl/pcrs_pkg.sv]
package pcrs_pkg;

   localparam int MAX_PARTICLES = 32;
   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int AXES = 3;
   localparam int VEC_W = 32 * AXES;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_ANCHOR = 2'd1;
   localparam logic [1:0] MODE_STEP = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] REG_ELASTICITY = 2'd0;
   localparam logic [1:0] REG_MIN_SPACING = 2'd1;
   localparam logic [1:0] REG_PARTICLE_COUNT = 2'd2;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic             load_we;
      logic             capture;
      logic             prep;
      logic             fill;
      logic             rd;
      logic             lap;
      logic             sq;
      logic             vel;
      logic             mul;
      logic             pos;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/particle_chain_relax_step_core.sv]
// Particle chain stepped by semi-implicit Euler under a discrete spring law.
// Mode 0 and mode 1 transactions write a position. A mode 2 transaction runs
// one step: after a prepare state and a fill state, each of the n particles in
// use goes through one shared sequence (read, Laplacian, products, velocity,
// move product, position write). Positions of particles 0 to n-1 then appear
// in order, one per strobe, with rsp_last on the final one. The receiver
// cannot stall: each result is present for one cycle only.
module particle_chain_relax_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [4:0]         req_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_step_time,
   output logic               rsp_valid,
   output logic [4:0]         rsp_out_index,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [23:0]                elasticity_ff;
   logic [30:0]                min_spacing_ff;
   logic [5:0]                 count_ff;
   logic                       wr;
   logic                       clear;
   logic [7:0]                 n_eff;
   logic [pcrs_pkg::IDX_W-1:0] n_last;
   pcrs_pkg::cmd_type          cmd;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && pready;
   assign clear = wr && (paddr[3:2] == pcrs_pkg::REG_PARTICLE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         elasticity_ff <= 24'd65536;
         min_spacing_ff <= '0;
         count_ff <= 6'd32;
      end else if (wr) begin
         unique case (paddr[3:2])
            pcrs_pkg::REG_ELASTICITY:     elasticity_ff <= pwdata[23:0];
            pcrs_pkg::REG_MIN_SPACING:    min_spacing_ff <= pwdata[30:0];
            pcrs_pkg::REG_PARTICLE_COUNT: count_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         pcrs_pkg::REG_ELASTICITY:     prdata = 32'(elasticity_ff);
         pcrs_pkg::REG_MIN_SPACING:    prdata = 32'(min_spacing_ff);
         pcrs_pkg::REG_PARTICLE_COUNT: prdata = 32'(count_ff);
         default:                      prdata = '0;
      endcase
   end

   always_comb begin
      if (count_ff < 6'd2) begin
         n_eff = 8'd2;
      end else if (8'(count_ff) > 8'(pcrs_pkg::MAX_PARTICLES)) begin
         n_eff = 8'(pcrs_pkg::MAX_PARTICLES);
      end else begin
         n_eff = 8'(count_ff);
      end
      n_last = pcrs_pkg::IDX_W'(n_eff - 8'd1);
   end

   pcrs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_mode),
      .n_last(n_last), .busy(busy), .cmd(cmd)
   );

   pcrs_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .clear(clear),
      .mode(req_mode), .index(req_index),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .step_time(req_step_time), .elasticity(elasticity_ff),
      .min_spacing(min_spacing_ff),
      .out_valid(rsp_valid), .out_index(rsp_out_index),
      .out_x(rsp_out_x), .out_y(rsp_out_y), .out_z(rsp_out_z),
      .out_last(rsp_last)
   );

endmodule

[rtl/pcrs_ram.sv]
module pcrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/pcrs_ctrl.sv]
module pcrs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  mode,
   input  logic [pcrs_pkg::IDX_W-1:0]  n_last,
   output logic                        busy,
   output pcrs_pkg::cmd_type           cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_FILL = 4'd2;
   localparam logic [3:0] ST_RD   = 4'd3;
   localparam logic [3:0] ST_LAP  = 4'd4;
   localparam logic [3:0] ST_SQ   = 4'd5;
   localparam logic [3:0] ST_VEL  = 4'd6;
   localparam logic [3:0] ST_MUL  = 4'd7;
   localparam logic [3:0] ST_POS  = 4'd8;

   logic [3:0]                 state_ff, state_in;
   logic [pcrs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (mode == pcrs_pkg::MODE_STEP)) begin
               state_in = ST_PREP;
               idx_in = '0;
            end
         end
         ST_PREP: state_in = ST_FILL;
         ST_FILL: state_in = ST_RD;
         ST_RD:   state_in = ST_LAP;
         ST_LAP:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_VEL;
         ST_VEL:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_POS;
         ST_POS: begin
            if (idx_ff == n_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      cmd.load_we = accept && ((mode == pcrs_pkg::MODE_LOAD) ||
                               (mode == pcrs_pkg::MODE_ANCHOR));
      cmd.capture = accept && (mode == pcrs_pkg::MODE_STEP);
      cmd.prep = (state_ff == ST_PREP);
      cmd.fill = (state_ff == ST_FILL);
      cmd.rd = (state_ff == ST_RD);
      cmd.lap = (state_ff == ST_LAP);
      cmd.sq = (state_ff == ST_SQ);
      cmd.vel = (state_ff == ST_VEL);
      cmd.mul = (state_ff == ST_MUL);
      cmd.pos = (state_ff == ST_POS);
      cmd.first = (idx_ff == '0);
      cmd.last = (idx_ff == n_last);
      cmd.idx = idx_ff;
   end

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_we |-> (state_ff == ST_IDLE))
      else $error("position load while a step is running");

   a_idx_in_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (idx_ff <= n_last))
      else $error("particle index ran past the chain");

   a_pos_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS) |-> ($past(state_ff) == ST_MUL))
      else $error("position update without its move product");

   a_step_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_POS) && (state_in == ST_IDLE)) |-> (idx_ff == n_last))
      else $error("step ended before the last particle");

endmodule

[rtl/pcrs_dpath.sv]
module pcrs_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  pcrs_pkg::cmd_type           cmd,
   input  logic                        clear,
   input  logic [1:0]                  mode,
   input  logic [4:0]                  index,
   input  logic signed [31:0]          pos_x,
   input  logic signed [31:0]          pos_y,
   input  logic signed [31:0]          pos_z,
   input  logic [15:0]                 step_time,
   input  logic [23:0]                 elasticity,
   input  logic [30:0]                 min_spacing,
   output logic                        out_valid,
   output logic [4:0]                  out_index,
   output logic signed [31:0]          out_x,
   output logic signed [31:0]          out_y,
   output logic signed [31:0]          out_z,
   output logic                        out_last
);

   localparam int N = pcrs_pkg::MAX_PARTICLES;
   localparam int IW = pcrs_pkg::IDX_W;
   localparam int A = pcrs_pkg::AXES;

   logic                       pos_vld_ff [N];
   logic                       vel_vld_ff [N];
   logic                       pos_rv_ff, vel_rv_ff;

   logic                       pos_we, vel_we;
   logic [IW-1:0]              pos_waddr, pos_raddr, vel_raddr;
   logic [pcrs_pkg::VEC_W-1:0] pos_wdata, vel_wdata, pos_rdata, vel_rdata;
   logic                       load_hit;
   logic [IW-1:0]              load_addr;

   logic [15:0]                dt_ff;
   logic [23:0]                k_ff;
   logic [61:0]                lim_ff;
   logic [39:0]                k_prod;
   logic signed [31:0]         pprev_ff [A];
   logic signed [31:0]         pcur_ff [A];
   logic signed [31:0]         pnext_ff [A];
   logic signed [31:0]         vold_ff [A];
   logic signed [31:0]         lap_ff [A];
   logic [63:0]                sq_ff [A];
   logic signed [56:0]         kl_ff [A];
   logic signed [31:0]         vnew_ff [A];
   logic signed [48:0]         mv_ff [A];
   logic signed [31:0]         rd_pos [A];
   logic signed [31:0]         rd_vel [A];
   logic signed [31:0]         lap_in [A];
   logic signed [31:0]         vnew_in [A];
   logic signed [31:0]         pnew [A];
   logic signed [31:0]         dv [A];
   logic signed [31:0]         vsum [A];
   logic signed [63:0]         sq_s [A];
   logic [65:0]                norm;
   logic                       over;

   logic                       out_valid_ff;
   logic [4:0]                 out_index_ff;
   logic signed [31:0]         out_x_ff, out_y_ff, out_z_ff;
   logic                       out_last_ff;

   assign load_addr = (mode == pcrs_pkg::MODE_ANCHOR) ? '0 : IW'(index);
   assign load_hit = (mode == pcrs_pkg::MODE_ANCHOR) || (32'(index) < N);

   assign pos_we = (cmd.load_we && load_hit) || cmd.pos;
   assign pos_waddr = cmd.load_we ? load_addr : cmd.idx;
   assign pos_wdata = cmd.load_we ? {pos_z, pos_y, pos_x} : {pnew[2], pnew[1], pnew[0]};
   assign pos_raddr = cmd.prep ? '0 : IW'(cmd.idx + 1'b1);
   assign vel_we = cmd.pos && !cmd.first;
   assign vel_raddr = cmd.idx;
   assign vel_wdata = {vnew_ff[2], vnew_ff[1], vnew_ff[0]};

   pcrs_ram #(.WIDTH(pcrs_pkg::VEC_W), .DEPTH(N)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata)
   );

   pcrs_ram #(.WIDTH(pcrs_pkg::VEC_W), .DEPTH(N)) u_vel_ram (
      .clock(clock), .we(vel_we), .waddr(cmd.idx), .wdata(vel_wdata),
      .raddr(vel_raddr), .rdata(vel_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int e = 0; e < N; e++) begin
            pos_vld_ff[e] <= 1'b0;
            vel_vld_ff[e] <= 1'b0;
         end
      end else begin
         if (pos_we) begin
            pos_vld_ff[pos_waddr] <= 1'b1;
         end
         if (vel_we) begin
            vel_vld_ff[cmd.idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_rv_ff <= pos_vld_ff[pos_raddr];
      vel_rv_ff <= vel_vld_ff[vel_raddr];
   end

   assign k_prod = 40'(dt_ff) * 40'(elasticity);

   always_comb begin
      for (int a = 0; a < A; a++) begin
         rd_pos[a] = pos_rv_ff ? pos_rdata[32*a +: 32] : '0;
         rd_vel[a] = vel_rv_ff ? vel_rdata[32*a +: 32] : '0;
         lap_in[a] = pcrs_pkg::sat32(64'(pprev_ff[a]) + 64'(rd_pos[a]) -
                                     (64'(pcur_ff[a]) <<< 1));
         sq_s[a] = lap_ff[a] * lap_ff[a];
         dv[a] = pcrs_pkg::sat32(64'(kl_ff[a] >>> 16));
         vsum[a] = pcrs_pkg::sat32(64'(vold_ff[a]) + 64'(dv[a]));
         pnew[a] = cmd.first ? pcur_ff[a] :
                   pcrs_pkg::sat32(64'(pcur_ff[a]) + 64'(mv_ff[a] >>> 16));
      end
      norm = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      over = norm > 66'(lim_ff);
      for (int a = 0; a < A; a++) begin
         if (cmd.first) begin
            vnew_in[a] = vold_ff[a];
         end else if (cmd.last || !over) begin
            vnew_in[a] = '0;
         end else begin
            vnew_in[a] = vsum[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dt_ff <= step_time;
      end
      if (cmd.prep) begin
         k_ff <= k_prod[39:16];
         lim_ff <= 62'(min_spacing) * 62'(min_spacing);
      end
      for (int a = 0; a < A; a++) begin
         if (cmd.fill) begin
            pcur_ff[a] <= rd_pos[a];
         end
         if (cmd.lap) begin
            pnext_ff[a] <= rd_pos[a];
            vold_ff[a] <= rd_vel[a];
            lap_ff[a] <= lap_in[a];
         end
         if (cmd.sq) begin
            sq_ff[a] <= 64'(sq_s[a]);
            kl_ff[a] <= $signed({1'b0, k_ff}) * lap_ff[a];
         end
         if (cmd.vel) begin
            vnew_ff[a] <= vnew_in[a];
         end
         if (cmd.mul) begin
            mv_ff[a] <= vnew_ff[a] * $signed({1'b0, dt_ff});
         end
         if (cmd.pos) begin
            pprev_ff[a] <= pcur_ff[a];
            pcur_ff[a] <= pnext_ff[a];
         end
      end
      if (cmd.pos) begin
         out_index_ff <= 5'(cmd.idx);
         out_x_ff <= pnew[0];
         out_y_ff <= pnew[1];
         out_z_ff <= pnew[2];
         out_last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cmd.pos;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;
   assign out_x = out_x_ff;
   assign out_y = out_y_ff;
   assign out_z = out_z_ff;
   assign out_last = out_last_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 5000;
   localparam int MAX_PARTICLES = pcrs_pkg::MAX_PARTICLES;
   localparam logic [1:0] MODE_LOAD = pcrs_pkg::MODE_LOAD;
   localparam logic [1:0] MODE_ANCHOR = pcrs_pkg::MODE_ANCHOR;
   localparam logic [1:0] MODE_STEP = pcrs_pkg::MODE_STEP;
   localparam logic [1:0] MODE_UNUSED = pcrs_pkg::MODE_UNUSED;
   localparam logic [1:0] REG_ELASTICITY = pcrs_pkg::REG_ELASTICITY;
   localparam logic [1:0] REG_MIN_SPACING = pcrs_pkg::REG_MIN_SPACING;
   localparam logic [1:0] REG_PARTICLE_COUNT = pcrs_pkg::REG_PARTICLE_COUNT;

   typedef struct packed {
      logic [4:0] idx;
      int         x;
      int         y;
      int         z;
      logic       last;
   } particle_out_type;

   typedef struct {
      logic [1:0]  mode;
      logic [4:0]  idx;
      int          x;
      int          y;
      int          z;
      logic [15:0] dt;
      bit          all_zero;
   } chain_cmd_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_mode;
   logic [4:0] req_index;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic [15:0] req_step_time;
   logic rsp_valid;
   logic [4:0] rsp_out_index;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_last;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   particle_chain_relax_step_core dut (.*);

   int pos_model [0:MAX_PARTICLES-1][0:2];
   int vel_model [0:MAX_PARTICLES-1][0:2];
   logic [23:0] gain_reg;
   logic [30:0] spacing_reg;
   logic [5:0] count_reg;

   particle_out_type positions_due[$];
   int mismatches;
   int results_seen;
   int steps_sent;
   int loads_sent;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_s32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic void clear_chain();
      for (int i = 0; i < MAX_PARTICLES; i++) begin
         for (int a = 0; a < 3; a++) begin
            pos_model[i][a] = 0;
            vel_model[i][a] = 0;
         end
      end
   endfunction

   function automatic int used_particles();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MAX_PARTICLES) n = MAX_PARTICLES;
      return n;
   endfunction

   function automatic void relax_chain(logic [15:0] dt, bit all_zero);
      int n;
      longint gain;
      longint unsigned limit_sq;
      longint unsigned norm;
      int lap [0:2];
      particle_out_type p;
      n = used_particles();
      gain = longint'((64'(dt) * 64'(gain_reg)) >> 16);
      limit_sq = 64'(spacing_reg) * 64'(spacing_reg);
      for (int i = 1; i < n - 1; i++) begin
         norm = 0;
         for (int a = 0; a < 3; a++) begin
            lap[a] = clamp_s32(longint'(pos_model[i-1][a]) + longint'(pos_model[i+1][a])
                               - 2 * longint'(pos_model[i][a]));
            norm += longint'(lap[a]) * longint'(lap[a]);
         end
         for (int a = 0; a < 3; a++) begin
            if (norm > limit_sq) begin
               vel_model[i][a] = clamp_s32(longint'(vel_model[i][a])
                                 + longint'(clamp_s32((gain * longint'(lap[a])) >>> 16)));
            end else begin
               vel_model[i][a] = 0;
            end
         end
      end
      for (int a = 0; a < 3; a++) vel_model[n-1][a] = 0;
      for (int i = 1; i < n; i++) begin
         for (int a = 0; a < 3; a++) begin
            pos_model[i][a] = clamp_s32(longint'(pos_model[i][a])
                              + ((longint'(vel_model[i][a]) * longint'(dt)) >>> 16));
         end
      end
      for (int i = 0; i < n; i++) begin
         p.idx = 5'(i);
         p.x = all_zero ? 0 : pos_model[i][0];
         p.y = all_zero ? 0 : pos_model[i][1];
         p.z = all_zero ? 0 : pos_model[i][2];
         p.last = (i == n - 1);
         positions_due.push_back(p);
      end
   endfunction

   function automatic void apply_command(chain_cmd_type c);
      int slot;
      if (c.mode == MODE_LOAD || c.mode == MODE_ANCHOR) begin
         slot = (c.mode == MODE_ANCHOR) ? 0 : int'(c.idx);
         pos_model[slot][0] = c.x;
         pos_model[slot][1] = c.y;
         pos_model[slot][2] = c.z;
         loads_sent++;
      end else if (c.mode == MODE_STEP) begin
         relax_chain(c.dt, c.all_zero);
         steps_sent++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_command(chain_cmd_type c);
      int gap;
      start <= 1'b1;
      req_mode <= c.mode;
      req_index <= c.idx;
      req_pos_x <= c.x;
      req_pos_y <= c.y;
      req_pos_z <= c.z;
      req_step_time <= c.dt;
      do @(posedge clock); while (busy);
      apply_command(c);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (positions_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] which, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {which, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (which)
         REG_ELASTICITY: gain_reg = value[23:0];
         REG_MIN_SPACING: spacing_reg = value[30:0];
         default: begin
            count_reg = value[5:0];
            clear_chain();
         end
      endcase
   endtask

   function automatic int random_coord();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return int'($urandom);
      if (r == 1) return 0;
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   function automatic chain_cmd_type random_command(int n);
      chain_cmd_type c;
      int r;
      r = $urandom_range(0, 9);
      c.mode = MODE_LOAD;
      c.idx = 5'($urandom_range(0, n - 1));
      c.x = random_coord();
      c.y = random_coord();
      c.z = random_coord();
      c.dt = 16'($urandom);
      c.all_zero = 1'b0;
      if ($urandom_range(0, 5) == 0) c.dt = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      if (r == 0) begin
         c.mode = 2'($urandom);
         c.idx = 5'($urandom);
      end else if (r == 1) begin
         c.idx = 5'($urandom);
      end else if (r == 6) begin
         c.mode = MODE_ANCHOR;
      end else if (r >= 7) begin
         c.mode = MODE_STEP;
      end
      return c;
   endfunction

   always @(posedge clock) begin
      particle_out_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_out_index, rsp_out_x, rsp_out_y, rsp_out_z, rsp_last};
         results_seen++;
         if (positions_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: index %0d x %0d y %0d z %0d last %0b",
                        got.idx, got.x, got.y, got.z, got.last);
         end else begin
            want = positions_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected index %0d x %0d y %0d z %0d last %0b,",
                           want.idx, want.x, want.y, want.z, want.last);
                  $display("          got index %0d x %0d y %0d z %0d last %0b",
                           got.idx, got.x, got.y, got.z, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog expired with %0d results outstanding", positions_due.size());
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      chain_cmd_type directed [0:10];
      logic [23:0] gains [0:6];
      logic [30:0] spacings [0:6];
      logic [5:0] counts [0:6];
      chain_cmd_type c;
      int n;
      directed = '{
         '{MODE_STEP, 5'd0, 0, 0, 0, 16'hffff, 1'b1},
         '{MODE_LOAD, 5'd1, 32'h7fffffff, 32'h80000000, 0, 16'h0, 1'b0},
         '{MODE_LOAD, 5'd2, 32'h80000000, 32'h7fffffff, -1, 16'h0, 1'b0},
         '{MODE_LOAD, 5'd0, 32'h0001_0000, -32'h0002_0000, 5, 16'h0, 1'b0},
         '{MODE_ANCHOR, 5'd17, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h0, 1'b0},
         '{MODE_LOAD, 5'd31, -32'h0001_0000, 32'h5555_aaaa, 32'haaaa_5555, 16'h0, 1'b0},
         '{MODE_UNUSED, 5'd9, 32'h1234_5678, 1, 2, 16'hffff, 1'b0},
         '{MODE_STEP, 5'd31, 0, 0, 0, 16'hffff, 1'b0},
         '{MODE_STEP, 5'd0, 0, 0, 0, 16'h0000, 1'b0},
         '{MODE_LOAD, 5'd30, 32'hffff_ffff, 32'h0000_ffff, 32'hffff_0000, 16'h0, 1'b0},
         '{MODE_STEP, 5'd0, 0, 0, 0, 16'h0001, 1'b0}
      };
      gains = '{24'hffffff, 24'h0, 24'h010000, 24'($urandom), 24'($urandom),
                24'h000001, 24'($urandom)};
      spacings = '{31'h0, 31'h0, 31'h0001_0000, 31'h7fffffff, 31'($urandom_range(0, 4096)),
                   31'h0, 31'($urandom_range(0, 32'h0008_0000))};
      counts = '{6'd2, 6'd3, 6'd8, 6'd32, 6'd0, 6'd63, 6'($urandom_range(4, 31))};
      start = 1'b0;
      req_mode = MODE_LOAD;
      req_index = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_step_time = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatches = 0;
      results_seen = 0;
      steps_sent = 0;
      loads_sent = 0;
      idle_cycles = 0;
      gain_reg = 24'h010000;
      spacing_reg = '0;
      count_reg = 6'd32;
      clear_chain();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_command(directed[i]);
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(REG_ELASTICITY, 32'(gains[ph]));
         write_reg(REG_MIN_SPACING, 32'(spacings[ph]));
         write_reg(REG_PARTICLE_COUNT, 32'(counts[ph]));
         n = used_particles();
         for (int k = 0; k < 14; k++) begin
            c = random_command(n);
            send_command(c);
         end
         c = random_command(n);
         c.mode = MODE_STEP;
         send_command(c);
         wait_idle();
      end

      repeat (50) @(posedge clock);
      $display("Ran %0d steps and %0d position loads over 8 register settings,",
               steps_sent, loads_sent);
      $display("checked %0d emitted positions, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && positions_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/pcrs_pkg.sv
rtl/pcrs_ram.sv
rtl/pcrs_ctrl.sv
rtl/pcrs_dpath.sv
rtl/particle_chain_relax_step_core.sv
bench/tb_top.sv
